[rtl/pul_pkg.sv]
// Shared types, constants and the factorial table for the permutation unranking block.
package pul_pkg;

    localparam int RankW = 16;
    localparam int ElemW = 3;
    localparam int LenW = 4;
    localparam int MaxRes = 8;

    localparam logic [LenW-1:0] PermLenReset = 4'd8;

    typedef logic [ElemW-1:0] elem_t;
    typedef logic [MaxRes-1:0][ElemW-1:0] digit_vec_t;

    // One rank travelling down the digit pipeline. digits[r-1] holds the
    // factorial-base digit of radix r, which is the digit of position len-r.
    typedef struct packed {
        logic                bad;
        logic [LenW-1:0]     len;
        logic [RankW-1:0]    rank;
        digit_vec_t          digits;
    } pul_item_t;

    function automatic logic [RankW:0] fact_of(input logic [LenW-1:0] n);
        logic [RankW:0] f;
        case (n) inside
            4'd0, 4'd1: f = 17'd1;
            4'd2:       f = 17'd2;
            4'd3:       f = 17'd6;
            4'd4:       f = 17'd24;
            4'd5:       f = 17'd120;
            4'd6:       f = 17'd720;
            4'd7:       f = 17'd5040;
            default:    f = 17'd40320;
        endcase
        return f;
    endfunction

endpackage

[rtl/pul_front.sv]
// Input register: clamps the length and flags ranks at or above length factorial.
module pul_front import pul_pkg::*; #(
    parameter int LenCap = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [RankW-1:0] rank_index,
    input  logic [LenW-1:0]  perm_length,
    output logic             out_valid,
    output pul_item_t        out_item
);

    logic            valid_reg;
    pul_item_t       item_reg;
    pul_item_t       item_next;
    logic [LenW-1:0] len_eff;

    always_comb
    begin
        if (perm_length == '0)
            len_eff = LenW'(1);
        else if (perm_length > LenW'(LenCap))
            len_eff = LenW'(LenCap);
        else
            len_eff = perm_length;

        item_next.len    = len_eff;
        item_next.rank   = rank_index;
        item_next.bad    = ({1'b0, rank_index} >= fact_of(len_eff));
        item_next.digits = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/pul_radix_stage.sv]
// Stage with a product register and a correction register that splits off one factorial-base digit by a constant radix.
module pul_radix_stage import pul_pkg::*; #(
    parameter int RADIX = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_valid,
    input  pul_item_t in_item,
    output logic      out_valid,
    output pul_item_t out_item
);

    // floor(2^16 / RADIX): the estimated quotient is exact or one too low.
    localparam logic [RankW-1:0] Recip  = RankW'((1 << RankW) / RADIX);
    localparam logic [RankW-1:0] RadixW = RankW'(RADIX);

    logic                   a_valid_reg;
    pul_item_t              a_item_reg;
    logic [2*RankW-1:0]     a_prod_reg;
    logic [2*RankW-1:0]     a_prod_next;

    logic                   b_valid_reg;
    pul_item_t              b_item_reg;
    pul_item_t              b_item_next;

    logic [RankW-1:0]       q_est;
    logic [RankW+3:0]       qk_full;
    logic [RankW-1:0]       rem_tmp;

    assign a_prod_next = {{RankW{1'b0}}, in_item.rank} * {{RankW{1'b0}}, Recip};

    always_comb
    begin
        q_est   = a_prod_reg[2*RankW-1:RankW];
        qk_full = {4'd0, q_est} * {{RankW{1'b0}}, 4'(RADIX)};
        rem_tmp = a_item_reg.rank - qk_full[RankW-1:0];

        b_item_next = a_item_reg;
        if (rem_tmp >= RadixW)
        begin
            b_item_next.rank = q_est + RankW'(1);
            b_item_next.digits[RADIX-1] = ElemW'(rem_tmp - RadixW);
        end
        else
        begin
            b_item_next.rank = q_est;
            b_item_next.digits[RADIX-1] = ElemW'(rem_tmp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_item_reg <= in_item;
            a_prod_reg <= a_prod_next;
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

[rtl/pul_emitter.sv]
// Sequencer: picks one element per unstalled cycle from the shrinking pool, drives output.
module pul_emitter import pul_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  pul_item_t  in_item,
    output logic       load,
    input  logic       out_stall,
    output logic       out_valid,
    output elem_t      element,
    output elem_t      position,
    output logic       last,
    output logic       bad_rank
);

    logic                 busy_reg, busy_next;
    logic [LenW-1:0]      radix_reg, radix_next;
    elem_t                pos_reg, pos_next;
    digit_vec_t           pool_reg, pool_next;
    digit_vec_t           digits_reg, digits_next;

    logic                 out_valid_reg, out_valid_next;
    elem_t                element_reg, element_next;
    elem_t                position_reg, position_next;
    logic                 last_reg, last_next;
    logic                 bad_reg, bad_next;

    logic                 out_free;
    logic                 issue;
    logic                 finishing;
    elem_t                digit;
    elem_t                pick;
    digit_vec_t           pool_shift;
    digit_vec_t           pool_init;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        issue     = busy_reg && out_free;
        finishing = issue && (radix_reg == LenW'(1));
        // The remaining pool size equals the radix of the current digit.
        digit     = digits_reg[ElemW'(radix_reg - LenW'(1))];
        pick      = pool_reg[digit];

        for (int k = 0; k < MaxRes - 1; k++)
            pool_shift[k] = (ElemW'(k) < digit) ? pool_reg[k] : pool_reg[k + 1];
        pool_shift[MaxRes-1] = pool_reg[MaxRes-1];

        for (int k = 0; k < MaxRes; k++)
            pool_init[k] = ElemW'(k);

        // A bad rank needs the output register at once; a good one only the sequencer.
        if (in_item.bad)
            load = in_valid && out_free && !busy_reg;
        else
            load = in_valid && (!busy_reg || finishing);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        radix_next     = radix_reg;
        pos_next       = pos_reg;
        pool_next      = pool_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg;
        element_next   = element_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;

        if (issue)
        begin
            out_valid_next = 1'b1;
            element_next   = pick;
            position_next  = pos_reg;
            last_next      = finishing;
            bad_next       = 1'b0;
            pos_next       = pos_reg + ElemW'(1);
            radix_next     = radix_reg - LenW'(1);
            pool_next      = pool_shift;
            if (finishing)
                busy_next = 1'b0;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            if (in_item.bad)
            begin
                out_valid_next = 1'b1;
                element_next   = '0;
                position_next  = '0;
                last_next      = 1'b1;
                bad_next       = 1'b1;
            end
            else
            begin
                busy_next   = 1'b1;
                radix_next  = in_item.len;
                pos_next    = '0;
                pool_next   = pool_init;
                digits_next = in_item.digits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg    <= radix_next;
        pos_reg      <= pos_next;
        pool_reg     <= pool_next;
        digits_reg   <= digits_next;
        element_reg  <= element_next;
        position_reg <= position_next;
        last_reg     <= last_next;
        bad_reg      <= bad_next;
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign position  = position_reg;
    assign last      = last_reg;
    assign bad_rank  = bad_reg;

endmodule

[rtl/permutation_unrank_lehmer_top.sv]
// Top level of the lexicographic permutation unranking block.
//
// A rank enters on in_valid/in_stall/rank_index and comes back as the permutation
// of 0..L-1 with that rank, one element per output item on out_valid/out_stall,
// in position order, with last set on the final one. A rank at or above L!
// gives a single item with bad_rank and last set and element and position zero.
// L is written through cfg_valid/cfg_ready/cfg_data; 0 counts as 1 and values
// above the cap of min(MAX_LENGTH, 8) count as the cap. Reset sets L to 8.
// The factorial-base digits are split off in a 15-register pipeline, one
// constant radix per two-register stage. A good item then passes through the
// sequencer to the output register; the item for a bad rank goes from the last
// stage straight to the output register. The sequencer emits one element per
// cycle while the output is not stalled, one per position of a good rank, and
// loads the next good rank as it issues the final one. The pipeline advances as a
// whole, so bubbles in it are not squeezed out; in_stall rises whenever an item
// waits in the last stage for the sequencer. When the receiver stalls, the output
// item holds and the sequencer with it, and the pipeline keeps moving until an
// item waits in its last stage. Reset empties the pipeline and the output register.
module permutation_unrank_lehmer_top import pul_pkg::*; #(
    parameter int MAX_LENGTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LenW-1:0]  cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [RankW-1:0] rank_index,
    output logic             out_valid,
    input  logic             out_stall,
    output elem_t            element,
    output elem_t            position,
    output logic             last,
    output logic             bad_rank
);

    localparam int LenCap = (MAX_LENGTH < MaxRes) ? MAX_LENGTH : MaxRes;

    logic [LenW-1:0] perm_length_reg;
    logic            advance;
    logic            load;

    // chain[0] is the input register; chain[r-1] follows the stage of radix r.
    logic [MaxRes-1:0] chain_valid;
    pul_item_t         chain_item [MaxRes];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            perm_length_reg <= PermLenReset;
        else if (cfg_valid && cfg_ready)
            perm_length_reg <= cfg_data;
    end

    // The pipeline moves as a whole whenever its last stage is empty or drains.
    assign advance  = !chain_valid[MaxRes-1] || load;
    assign in_stall = !advance;

    pul_front #(
        .LenCap      (LenCap)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .rank_index  (rank_index),
        .perm_length (perm_length_reg),
        .out_valid   (chain_valid[0]),
        .out_item    (chain_item[0])
    );

    for (genvar r = 2; r <= MaxRes; r++)
    begin : g_radix
        pul_radix_stage #(
            .RADIX     (r)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[r-2]),
            .in_item   (chain_item[r-2]),
            .out_valid (chain_valid[r-1]),
            .out_item  (chain_item[r-1])
        );
    end

    pul_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[MaxRes-1]),
        .in_item   (chain_item[MaxRes-1]),
        .load      (load),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .element   (element),
        .position  (position),
        .last      (last),
        .bad_rank  (bad_rank)
    );

endmodule

[rtl/pul_checker.sv]
// Port-level checks on the output sequence of the unranking block, bound to the top level.
module pul_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] element,
    input logic [2:0] position,
    input logic       last,
    input logic       bad_rank
);

    // A stalled output item holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(element) && $stable(position)
            && $stable(last) && $stable(bad_rank))
        else $error("output item changed while stalled");

    // A bad rank is reported as a lone, final item at position zero.
    a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_rank |-> last && element == 3'd0 && position == 3'd0)
        else $error("bad rank item malformed");

    // Elements of one permutation follow back to back with rising positions.
    a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && !bad_rank
            && position == 3'($past(position) + 3'd1))
        else $error("permutation items not consecutive");

endmodule

bind permutation_unrank_lehmer_top pul_checker u_pul_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .element   (element),
    .position  (position),
    .last      (last),
    .bad_rank  (bad_rank)
);

[tb/sv/tb_permutation_unrank_lehmer_top.sv]
// Self-checking testbench for the lexicographic permutation unranking block.
`timescale 1ns / 100ps

module tb_permutation_unrank_lehmer_top import pul_pkg::*;;

    localparam int MaxLength = 8;
    localparam int LenCap = (MaxLength < MaxRes) ? MaxLength : MaxRes;
    localparam int StallPct = 36;
    localparam int IdleLimit = 3000;
    localparam int RandPhases = 10;
    localparam int PhaseItems = 45;

    typedef struct packed {
        elem_t element;
        elem_t position;
        logic  last;
        logic  bad_rank;
    } perm_elem_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LenW-1:0]  cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [RankW-1:0] rank_index = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    elem_t            element;
    elem_t            position;
    logic             last;
    logic             bad_rank;

    perm_elem_t      pending_elems[$];
    logic [LenW-1:0] perm_len_cfg = PermLenReset;
    logic            steady_flow = 1'b0;
    int              mismatch_count = 0;
    int              quiet_cycles = 0;

    permutation_unrank_lehmer_top #(
        .MAX_LENGTH(MaxLength)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rank_index(rank_index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .element   (element),
        .position  (position),
        .last      (last),
        .bad_rank  (bad_rank)
    );

    always #5 clk = ~clk;

    function automatic int clamp_len(input logic [LenW-1:0] raw);
        int n;
        n = int'(raw);
        if (n < 1) n = 1;
        if (n > LenCap) n = LenCap;
        return n;
    endfunction

    function automatic int unsigned perm_count(input int n);
        int unsigned f;
        f = 1;
        for (int i = 2; i <= n; i++) f = f * i;
        return f;
    endfunction

    // Splits the rank into factorial-base digits and pulls each chosen value
    // out of the pool of unused values, queueing one element per position.
    function automatic void unrank_into_queue(input logic [RankW-1:0] r);
        int          len;
        int unsigned rest;
        int unsigned f;
        int          digit;
        int          pool[MaxRes];
        int          remaining;
        perm_elem_t  e;
        len = clamp_len(perm_len_cfg);
        rest = 32'(r);
        if (rest >= perm_count(len)) begin
            e = '{element: '0, position: '0, last: 1'b1, bad_rank: 1'b1};
            pending_elems = {pending_elems, e};
            return;
        end
        for (int i = 0; i < len; i++) pool[i] = i;
        remaining = len;
        for (int p = 0; p < len; p++) begin
            f = perm_count(len - 1 - p);
            digit = int'(rest / f);
            rest = rest % f;
            if (digit >= remaining) digit = remaining - 1;
            e.element = elem_t'(pool[digit]);
            e.position = elem_t'(p);
            e.last = (p == len - 1);
            e.bad_rank = 1'b0;
            for (int k = digit; k + 1 < remaining; k++) pool[k] = pool[k + 1];
            remaining--;
            pending_elems = {pending_elems, e};
        end
    endfunction

    // Mostly ranks below L!, with the rest spread over the whole field.
    function automatic logic [RankW-1:0] pick_rank();
        int unsigned top;
        top = perm_count(clamp_len(perm_len_cfg)) - 1;
        if ($urandom_range(99) < 85) return RankW'($urandom_range(top, 0));
        return RankW'($urandom_range(65535, 0));
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_rank(input logic [RankW-1:0] r);
        while (!steady_flow && $urandom_range(99) < StallPct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        rank_index <= r;
        do @(posedge clk); while (in_stall !== 1'b0);
        unrank_into_queue(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge clk);
    endtask

    // The caller drains the block first; consecutive writes are never issued.
    task automatic write_length(input logic [LenW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        perm_len_cfg = v;
    endtask

    task automatic test_default_length();
        send_rank(16'd0);
        send_rank(16'd1);
        send_rank(16'h5555);
        send_rank(16'd40319);
        send_rank(16'd40320);
        send_rank(16'hFFFF);
    endtask

    // Zero length acts as one, lengths above the cap act as the cap.
    task automatic test_length_extremes();
        wait_drained();
        write_length(4'd0);
        send_rank(16'd0);
        send_rank(16'd1);
        wait_drained();
        write_length(4'd15);
        send_rank(16'd40319);
        send_rank(16'd40320);
        wait_drained();
        write_length(4'd1);
        send_rank(16'd0);
        wait_drained();
        write_length(4'd9);
        send_rank(16'd12345);
        wait_drained();
        write_length(4'd2);
        send_rank(16'd1);
        send_rank(16'd2);
    endtask

    task automatic test_random_lengths();
        logic [LenW-1:0] len_pick;
        for (int ph = 0; ph < RandPhases; ph++) begin
            case (ph)
                0:       len_pick = 4'd8;
                1:       len_pick = 4'd1;
                2:       len_pick = 4'd15;
                default: len_pick = LenW'($urandom_range(15, 0));
            endcase
            wait_drained();
            write_length(len_pick);
            steady_flow = (ph == 3);
            for (int i = 0; i < PhaseItems; i++) send_rank(pick_rank());
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        wait_drained();
        write_length(4'd8);
        for (int i = 0; i < 6; i++) send_rank(pick_rank());
        wait_drained();
        for (int i = 0; i < 6; i++) send_rank(pick_rank());
    endtask

    always @(posedge clk) begin : result_check
        perm_elem_t got;
        perm_elem_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            got = '{element: element, position: position, last: last, bad_rank: bad_rank};
            if (pending_elems.size() == 0) begin
                flag_mismatch("unexpected result, element", got.element, -1);
            end else begin
                want = pending_elems.pop_front();
                if (got.element !== want.element)
                    flag_mismatch("element", got.element, want.element);
                if (got.position !== want.position)
                    flag_mismatch("position", got.position, want.position);
                if (got.last !== want.last)
                    flag_mismatch("last", got.last, want.last);
                if (got.bad_rank !== want.bad_rank)
                    flag_mismatch("bad_rank", got.bad_rank, want.bad_rank);
            end
        end
        out_stall <= !steady_flow && ($urandom_range(99) < StallPct);
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
                    || (cfg_valid && cfg_ready === 1'b1))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IdleLimit) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_length();
        test_length_extremes();
        test_pause_until_drained();
        test_random_lengths();
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_elems.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[permutation_unrank_lehmer_top.f]
rtl/pul_pkg.sv
rtl/pul_front.sv
rtl/pul_radix_stage.sv
rtl/pul_emitter.sv
rtl/permutation_unrank_lehmer_top.sv
rtl/pul_checker.sv
tb/sv/tb_permutation_unrank_lehmer_top.sv
